// ===== hdl/kms_pkg.sv =====
package kms_pkg;

  localparam int unsigned RowW     = 4;
  localparam int unsigned ColW     = 2;
  localparam int unsigned CodeW    = 5;
  localparam int unsigned SettleW  = 8;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETTLE  = 2'd0,
    REG_HOLD    = 2'd1,
    REG_RELEASE = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_SETTLE  = 3'd0,
    PH_HOLD    = 3'd1,
    PH_WAIT    = 3'd2,
    PH_RELEASE = 3'd3
  } phase_e;

  typedef struct packed {
    logic [SettleW-1:0] settle_ticks;
    logic [DelayW-1:0]  hold_ticks;
    logic [DelayW-1:0]  release_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [ColW-1:0]   column;
    logic [ColW-1:0]   pressed_row;
    logic [DelayW-1:0] counter;
  } scan_state_t;

  typedef struct packed {
    logic [CodeW-1:0] key_code;
    logic             key_valid;
    logic [RowW-1:0]  column_drive;
  } result_t;

  // Key codes indexed by {column, row}.
  localparam logic [CodeW-1:0] KEY_TABLE [16] = '{
    5'd1,  5'd4,  5'd7,  5'd11,
    5'd2,  5'd5,  5'd8,  5'd10,
    5'd3,  5'd6,  5'd9,  5'd12,
    5'd13, 5'd14, 5'd15, 5'd16
  };

endpackage

// ===== hdl/keypad_matrix_scanner_unit.sv =====
// 4x4 keypad scanner, advanced by one time-base tick per input request.
// Each request carries the sampled row lines and yields exactly one result:
// the column drive for that tick, plus a key code on the tick a press is
// reported. The scan state and the result register are updated at the edge
// where the request is accepted, so a new request is taken every cycle as
// long as the output side keeps up (the result register is the only buffer;
// tready drops only while it is full and stalled). Configuration writes are
// always accepted (cfg_ready is tied high) and should be issued only while
// the scanner is idle.
module keypad_matrix_scanner_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kms_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [kms_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [kms_pkg::InDataW-1:0]     s_axis_tdata,  // [3:0] row_lines
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] column_drive, [4] key_valid, [9:5] key_code
  output logic [kms_pkg::OutDataW-1:0]    m_axis_tdata
);

  kms_pkg::cfg_t        cfg_q;
  kms_pkg::scan_state_t state_q, state_d;
  kms_pkg::result_t     res_q, res_d;
  logic                 out_valid_q;
  logic                 in_fire;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks  <= 8'd1;
      cfg_q.hold_ticks    <= 16'd250;
      cfg_q.release_ticks <= 16'd100;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        kms_pkg::REG_SETTLE:  cfg_q.settle_ticks  <= cfg_data_i[kms_pkg::SettleW-1:0];
        kms_pkg::REG_HOLD:    cfg_q.hold_ticks    <= cfg_data_i;
        kms_pkg::REG_RELEASE: cfg_q.release_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kms_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .rows_i   (s_axis_tdata[kms_pkg::RowW-1:0]),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= kms_pkg::PH_SETTLE;
      state_q.column      <= '0;
      state_q.pressed_row <= '0;
      state_q.counter     <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      // Hold the result while the consumer stalls.
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, res_q.key_code, res_q.key_valid, res_q.column_drive};

  a_press_enters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_d.key_valid) |=> (state_q.phase == kms_pkg::PH_HOLD))
    else $error("reported key did not enter hold");

  a_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(~m_axis_tdata[3:0]))
    else $error("column drive not one-cold");

  a_code_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4] == (m_axis_tdata[9:5] != 5'd0)))
    else $error("key code disagrees with key valid");

  a_counter_only_in_timed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == kms_pkg::PH_WAIT) |-> (state_q.counter == '0))
    else $error("counter running while waiting for release");

endmodule

// ===== hdl/kms_step.sv =====
module kms_step (
  input  kms_pkg::cfg_t              cfg_i,
  input  kms_pkg::scan_state_t       state_i,
  input  logic [kms_pkg::RowW-1:0]   rows_i,
  output kms_pkg::scan_state_t       state_o,
  output kms_pkg::result_t           result_o
);

  logic                         any_low;
  logic                         settling;
  logic [kms_pkg::ColW-1:0]     low_row;
  logic [kms_pkg::DelayW-1:0]   cnt_inc;
  logic [kms_pkg::ColW-1:0]     col_next;

  assign cnt_inc  = state_i.counter + 16'd1;
  assign col_next = state_i.column + 2'd1;
  assign any_low  = (rows_i != 4'hF);
  assign settling = (state_i.counter < {8'd0, cfg_i.settle_ticks});

  // Lowest-numbered low row wins.
  always_comb begin
    low_row = 2'd3;
    for (int r = kms_pkg::RowW - 1; r >= 0; r--) begin
      if (!rows_i[r]) begin
        low_row = r[kms_pkg::ColW-1:0];
      end
    end
  end

  always_comb begin
    state_o = state_i;
    case (state_i.phase)
      kms_pkg::PH_SETTLE: begin
        if (settling) begin
          state_o.counter = cnt_inc;
        end else if (any_low) begin
          state_o.pressed_row = low_row;
          state_o.phase       = kms_pkg::PH_HOLD;
          state_o.counter     = '0;
        end else begin
          state_o.column  = col_next;
          state_o.counter = '0;
        end
      end
      kms_pkg::PH_HOLD: begin
        if (state_i.counter < cfg_i.hold_ticks) begin
          state_o.counter = cnt_inc;
        end else begin
          state_o.phase   = kms_pkg::PH_WAIT;
          state_o.counter = '0;
        end
      end
      kms_pkg::PH_WAIT: begin
        if (rows_i[state_i.pressed_row]) begin
          state_o.phase   = kms_pkg::PH_RELEASE;
          state_o.counter = '0;
        end
      end
      kms_pkg::PH_RELEASE: begin
        if (state_i.counter < cfg_i.release_ticks) begin
          state_o.counter = cnt_inc;
        end else begin
          state_o.column  = col_next;
          state_o.phase   = kms_pkg::PH_SETTLE;
          state_o.counter = '0;
        end
      end
      default: begin
        state_o.phase   = kms_pkg::PH_SETTLE;
        state_o.counter = '0;
      end
    endcase
  end

  // Report a key only on the settle tick that samples a pressed row.
  always_comb begin
    result_o.column_drive  = ~(4'b0001 << state_i.column);
    result_o.key_valid     = 1'b0;
    result_o.key_code      = '0;
    if ((state_i.phase == kms_pkg::PH_SETTLE) && !settling && any_low) begin
      result_o.key_valid = 1'b1;
      result_o.key_code  = kms_pkg::KEY_TABLE[{state_i.column, low_row}];
    end
  end

endmodule

// ===== test/kms_scan_checker.sv =====
module kms_scan_checker
  import kms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         owed_count_o
);

  localparam logic [SettleW-1:0] SettleAtReset  = 8'd1;
  localparam logic [DelayW-1:0]  HoldAtReset    = 16'd250;
  localparam logic [DelayW-1:0]  ReleaseAtReset = 16'd100;
  localparam int unsigned        ResW           = $bits(result_t);

  cfg_t        timing;
  scan_state_t scan;
  result_t     owed_scan_results [$];
  int unsigned mismatch_total;

  function automatic void step_column();
    scan.column  = scan.column + 1'b1;
    scan.phase   = PH_SETTLE;
    scan.counter = '0;
  endfunction

  // Advance the scanner by one tick and return what it shows on that tick.
  function automatic result_t scan_one_tick(input logic [RowW-1:0] rows);
    result_t res;
    int      r;
    res              = '0;
    res.column_drive = ~(RowW'(1) << scan.column);
    case (scan.phase)
      PH_HOLD: begin
        if (scan.counter < timing.hold_ticks) begin
          scan.counter = scan.counter + 1'b1;
        end else begin
          scan.phase   = PH_WAIT;
          scan.counter = '0;
        end
      end
      PH_WAIT: begin
        if (rows[scan.pressed_row]) begin
          scan.phase   = PH_RELEASE;
          scan.counter = '0;
        end
      end
      PH_RELEASE: begin
        if (scan.counter < timing.release_ticks) begin
          scan.counter = scan.counter + 1'b1;
        end else begin
          step_column();
        end
      end
      PH_SETTLE: begin
        if (scan.counter < DelayW'(timing.settle_ticks)) begin
          scan.counter = scan.counter + 1'b1;
        end else if (rows != '1) begin
          // lowest pressed row wins
          r = 0;
          while (rows[r]) r++;
          res.key_valid    = 1'b1;
          res.key_code     = KEY_TABLE[int'(scan.column) * 4 + r];
          scan.pressed_row = ColW'(r);
          scan.phase       = PH_HOLD;
          scan.counter     = '0;
        end else begin
          step_column();
        end
      end
      default: begin
        scan.phase   = PH_SETTLE;
        scan.counter = '0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    if (!rst_ni) begin
      timing = '{settle_ticks: SettleAtReset, hold_ticks: HoldAtReset,
                 release_ticks: ReleaseAtReset};
      scan           = '0;
      mismatch_total = 0;
      owed_scan_results.delete();
      fail_count_o <= 0;
      owed_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SETTLE:  timing.settle_ticks  = cfg_data_i[SettleW-1:0];
          REG_HOLD:    timing.hold_ticks    = cfg_data_i[DelayW-1:0];
          REG_RELEASE: timing.release_ticks = cfg_data_i[DelayW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        owed_scan_results.push_back(scan_one_tick(s_tdata_i[RowW-1:0]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[ResW-1:0]);
        if (owed_scan_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_tdata_i);
          mismatch_total++;
        end else begin
          want = owed_scan_results.pop_front();
          if (got.column_drive !== want.column_drive) begin
            $error("column_drive: expected %h, got %h", want.column_drive, got.column_drive);
            mismatch_total++;
          end
          if (got.key_valid !== want.key_valid) begin
            $error("key_valid: expected %0d, got %0d", want.key_valid, got.key_valid);
            mismatch_total++;
          end
          if (got.key_code !== want.key_code) begin
            $error("key_code: expected %0d, got %0d", want.key_code, got.key_code);
            mismatch_total++;
          end
          if (m_tdata_i[OutDataW-1:ResW] !== '0) begin
            $error("tdata padding: expected 0, got %h", m_tdata_i[OutDataW-1:ResW]);
            mismatch_total++;
          end
        end
      end
      fail_count_o <= mismatch_total;
      owed_count_o <= owed_scan_results.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import kms_pkg::*;

  localparam int unsigned    StallLimit  = 2000;
  localparam int unsigned    DrainCycles = 4;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  // at reset timing column 0 sees no key, column 1 sees every row low
  localparam logic [RowW-1:0] ResetTicks [6] = '{4'hF, 4'hF, 4'hF, 4'h0, 4'h5, 4'hA};
  // zero delays: settle, hold and release each end on their first tick
  localparam logic [RowW-1:0] ZeroDelayTicks [20] = '{
    4'h7, 4'hF, 4'h0, 4'h8, 4'h0,
    4'h0, 4'h0, 4'hE, 4'h1, 4'hF,
    4'h9, 4'hF, 4'hF, 4'hF, 4'hF,
    4'hD, 4'hF, 4'hF, 4'hF, 4'hB
  };

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index     = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned owed_count;
  int unsigned sink_hold_cycles = 0;
  bit          gaps_off         = 1'b0;
  int unsigned feed_calm        = 0;
  int unsigned sink_calm        = 0;

  keypad_matrix_scanner_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  kms_scan_checker check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .owed_count_o (owed_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(ref int unsigned calm_left);
    if (gaps_off) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic send_tick(input logic [RowW-1:0] rows);
    int unsigned gap;
    gap = draw_gap(feed_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - RowW){1'b0}}, rows};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold the input side until every owed result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [SettleW-1:0] settle, input logic [DelayW-1:0] hold,
                            input logic [DelayW-1:0] rel);
    wait_drained();
    // upper bits of the settle write are dropped by the block
    write_reg(REG_SETTLE, {8'($urandom), settle});
    if ($urandom_range(0, 1)) write_reg(RegUnused, 16'($urandom));
    write_reg(REG_HOLD, hold);
    write_reg(REG_RELEASE, rel);
  endtask

  // Mostly press/release strokes with some bounce, plus stretches of noise.
  task automatic run_keystrokes(input int unsigned n_ticks, input int unsigned span,
                                input bit pause_mid);
    int unsigned     done;
    int unsigned     len;
    logic [RowW-1:0] held;
    logic [RowW-1:0] rows;
    done = 0;
    while (done < n_ticks) begin
      if ($urandom_range(0, 3) != 0) begin
        held = RowW'($urandom);
        if (held == '1) held[$urandom_range(0, RowW - 1)] = 1'b0;
        len = $urandom_range(1, span);
        for (int i = 0; i < len && done < n_ticks; i++) begin
          rows = ($urandom_range(0, 9) == 0) ? RowW'($urandom) : held;
          send_tick(rows);
          done++;
          if (pause_mid && done == n_ticks / 2) wait_drained();
        end
        len = $urandom_range(1, span);
        for (int i = 0; i < len && done < n_ticks; i++) begin
          rows = ($urandom_range(0, 9) == 0) ? (RowW'($urandom) | ~held) : '1;
          send_tick(rows);
          done++;
          if (pause_mid && done == n_ticks / 2) wait_drained();
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len && done < n_ticks; i++) begin
          send_tick(RowW'($urandom));
          done++;
          if (pause_mid && done == n_ticks / 2) wait_drained();
        end
      end
    end
  endtask

  initial begin : result_sink
    int unsigned wait_n;
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end
      wait_n = draw_gap(sink_calm);
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready) || !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (ResetTicks[i]) send_tick(ResetTicks[i]);
    set_timing(8'd0, 16'd0, 16'd0);
    foreach (ZeroDelayTicks[i]) send_tick(ZeroDelayTicks[i]);

    set_timing(8'd0, 16'd0, 16'd0);
    run_keystrokes(250, 6, 1'b1);

    set_timing(8'd1, 16'd250, 16'd100);
    run_keystrokes(300, 120, 1'b0);

    // starve the output long enough for the input side to back up
    set_timing(8'd2, 16'd3, 16'd2);
    sink_hold_cycles = 300;
    run_keystrokes(250, 10, 1'b0);

    set_timing(8'd255, 16'd65535, 16'd65535);
    gaps_off = 1'b1;
    run_keystrokes(300, 40, 1'b0);
    wait_drained();
    gaps_off = 1'b0;

    repeat (3) begin
      set_timing(SettleW'($urandom_range(0, 7)), DelayW'($urandom_range(0, 15)),
                 DelayW'($urandom_range(0, 15)));
      run_keystrokes(100, 20, 1'b1);
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/kms_pkg.sv
hdl/kms_step.sv
hdl/keypad_matrix_scanner_unit.sv
test/kms_scan_checker.sv
test/tb_top.sv
